>>> hw/rtl/spiral_order_matrix_reader_unit_macros.svh
// ----------------------------------------------------------------------------
// Spiral order matrix reader - assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SPIRAL_ORDER_MATRIX_READER_UNIT_MACROS_SVH
`define SPIRAL_ORDER_MATRIX_READER_UNIT_MACROS_SVH

// Same-cycle implication
`define SOMR_ASSERT_IMP(name, clk_s, rst_s, pre, post, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication
`define SOMR_ASSERT_NXT(name, clk_s, rst_s, pre, post, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> hw/rtl/somr_pkg.sv
// ----------------------------------------------------------------------------
// Spiral order matrix reader - package
// Default sizes, command and register codes, and the walk direction type.
// ----------------------------------------------------------------------------
package somr_pkg;

    // Default sizes
    localparam int MAX_DIM_DEF    = 64;
    localparam int ELEM_WIDTH_DEF = 16;

    // Configuration port
    localparam int CFG_WIDTH   = 7;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    // Input word commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    // Spiral walk direction
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

endpackage

>>> hw/rtl/somr_ram.sv
// ----------------------------------------------------------------------------
// Spiral order matrix reader - generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module somr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/spiral_order_matrix_reader_unit.sv
// ----------------------------------------------------------------------------
// Spiral order matrix reader
// Loads a rows-by-columns matrix in row-major order and returns its elements
// in clockwise spiral order, one per emit word.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   cmd, element_in
//   out      output     out_valid / out_stall element_out, last_of_spiral,
//                                             none_left
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// Sustained rate is one input word per cycle while the output is not stalled;
// the single RAM port pair and the walk registers, updated at acceptance, set that figure.
// An emit word passes the read stage (the RAM read data and the s1 registers
// load at the accepting edge), then enters the output register once that is
// free; a load word writes the RAM and gives no result.
// The matrix store is not cleared at reset; emission only reads loaded
// entries. Reset clears counters, bounds and the pipeline valid bits.
// A stalled output holds its word; input keeps flowing until the read stage
// and the output register are both full.
// ----------------------------------------------------------------------------
`include "spiral_order_matrix_reader_unit_macros.svh"

module spiral_order_matrix_reader_unit #(
    parameter int MAX_DIM    = somr_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = somr_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic signed [ELEM_WIDTH-1:0]        element_in,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ELEM_WIDTH-1:0]        element_out,
    output logic                                last_of_spiral,
    output logic                                none_left,
    // configuration port
    input  logic                                cfg_write,
    input  logic [somr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [somr_pkg::CFG_WIDTH-1:0]      cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int CW     = (DIM_W > somr_pkg::CFG_WIDTH) ? DIM_W : somr_pkg::CFG_WIDTH;
    localparam int PW     = IDX_W + DIM_W;

    // Clamp a dimension register into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [somr_pkg::CFG_WIDTH-1:0] v);
        logic [CW-1:0] ext;
        logic [DIM_W-1:0] res;
        ext = CW'(v);
        if (ext == '0)
        begin
            res = DIM_W'(1);
        end
        else if (ext > CW'(MAX_DIM))
        begin
            res = DIM_W'(MAX_DIM);
        end
        else
        begin
            res = DIM_W'(ext);
        end
        return res;
    endfunction

    // Registers
    logic [somr_pkg::CFG_WIDTH-1:0] rows_reg, cols_reg;
    logic [CNT_W-1:0]               loaded_reg, loaded_next;
    logic [CNT_W-1:0]               emitted_reg, emitted_next;
    logic [CNT_W-1:0]               spiral_total_reg, spiral_total_next;
    logic [DIM_W-1:0]               spiral_cols_reg, spiral_cols_next;
    logic [IDX_W-1:0]               top_reg, top_next;
    logic [IDX_W-1:0]               left_reg, left_next;
    logic [IDX_W-1:0]               bottom_reg, bottom_next;
    logic [IDX_W-1:0]               right_reg, right_next;
    logic [IDX_W-1:0]               row_reg, row_next;
    logic [IDX_W-1:0]               col_reg, col_next;
    somr_pkg::dir_t                 dir_reg, dir_next;
    logic                           s1_valid_reg, s1_valid_next;
    logic                           s1_none_reg, s1_none_next;
    logic                           s1_last_reg, s1_last_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_none_reg, out_last_reg;
    logic [ELEM_WIDTH-1:0]          out_elem_reg;

    // Datapath signals
    logic [DIM_W-1:0]      rows_c, cols_c;
    logic [2*DIM_W-1:0]    total_prod;
    logic [CNT_W-1:0]      total_cfg;
    logic                  in_accept, out_free, out_load;
    logic                  starting, emit_none, emit_last;
    logic [CNT_W-1:0]      total_use;
    logic [CNT_W-1:0]      emitted_inc;
    logic [IDX_W-1:0]      eff_top, eff_left, eff_bottom, eff_right, eff_row, eff_col;
    logic [DIM_W-1:0]      eff_cols;
    somr_pkg::dir_t        eff_dir;
    logic [IDX_W-1:0]      adv_top, adv_left, adv_bottom, adv_right, adv_row, adv_col;
    somr_pkg::dir_t        adv_dir;
    logic [PW-1:0]         addr_full;
    logic                  wr_en, rd_en;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    logic [ELEM_WIDTH-1:0] rd_data;

    // Dimensions in use and matrix size from the registers
    assign rows_c     = clamp_dim(rows_reg);
    assign cols_c     = clamp_dim(cols_reg);
    assign total_prod = rows_c * cols_c;
    assign total_cfg  = total_prod[CNT_W-1:0];

    // Handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // Effective walk state: fresh ring at the first emit of a matrix
    assign starting    = (emitted_reg == '0);
    assign eff_top     = starting ? '0 : top_reg;
    assign eff_left    = starting ? '0 : left_reg;
    assign eff_bottom  = starting ? IDX_W'(rows_c - DIM_W'(1)) : bottom_reg;
    assign eff_right   = starting ? IDX_W'(cols_c - DIM_W'(1)) : right_reg;
    assign eff_row     = starting ? '0 : row_reg;
    assign eff_col     = starting ? '0 : col_reg;
    assign eff_cols    = starting ? cols_c : spiral_cols_reg;
    assign eff_dir     = starting ? somr_pkg::DIR_RIGHT : dir_reg;
    assign total_use   = starting ? total_cfg : spiral_total_reg;
    assign emitted_inc = emitted_reg + CNT_W'(1);

    // Emit outcome: not loaded yet, or spiral finished
    assign emit_none = starting ? (loaded_reg < total_cfg) : (emitted_reg >= total_use);
    assign emit_last = (emitted_inc == total_use);

    // Row-major address of the current walk position
    assign addr_full = PW'(eff_row) * PW'(eff_cols) + PW'(eff_col);

    // One walk step inside the current ring
    always_comb
    begin
        adv_top    = eff_top;
        adv_left   = eff_left;
        adv_bottom = eff_bottom;
        adv_right  = eff_right;
        adv_row    = eff_row;
        adv_col    = eff_col;
        adv_dir    = eff_dir;
        unique case (eff_dir)
            somr_pkg::DIR_RIGHT:
            begin
                if (eff_col < eff_right)
                begin
                    adv_col = eff_col + IDX_W'(1);
                end
                else
                begin
                    adv_top = eff_top + IDX_W'(1);
                    adv_dir = somr_pkg::DIR_DOWN;
                    adv_row = eff_row + IDX_W'(1);
                end
            end
            somr_pkg::DIR_DOWN:
            begin
                if (eff_row < eff_bottom)
                begin
                    adv_row = eff_row + IDX_W'(1);
                end
                else
                begin
                    adv_right = eff_right - IDX_W'(1);
                    adv_dir   = somr_pkg::DIR_LEFT;
                    adv_col   = eff_col - IDX_W'(1);
                end
            end
            somr_pkg::DIR_LEFT:
            begin
                if (eff_col > eff_left)
                begin
                    adv_col = eff_col - IDX_W'(1);
                end
                else
                begin
                    adv_bottom = eff_bottom - IDX_W'(1);
                    adv_dir    = somr_pkg::DIR_UP;
                    adv_row    = eff_row - IDX_W'(1);
                end
            end
            somr_pkg::DIR_UP:
            begin
                if (eff_row > eff_top)
                begin
                    adv_row = eff_row - IDX_W'(1);
                end
                else
                begin
                    adv_left = eff_left + IDX_W'(1);
                    adv_dir  = somr_pkg::DIR_RIGHT;
                    adv_col  = eff_col + IDX_W'(1);
                end
            end
        endcase
    end

    // Counters, walk state and memory access
    always_comb
    begin
        loaded_next       = loaded_reg;
        emitted_next      = emitted_reg;
        spiral_total_next = spiral_total_reg;
        spiral_cols_next  = spiral_cols_reg;
        top_next          = top_reg;
        left_next         = left_reg;
        bottom_next       = bottom_reg;
        right_next        = right_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        dir_next          = dir_reg;
        wr_en             = 1'b0;
        wr_addr           = loaded_reg[ADDR_W-1:0];
        rd_en             = 1'b0;
        rd_addr           = addr_full[ADDR_W-1:0];
        if (in_accept && (cmd == somr_pkg::CMD_LOAD))
        begin
            // a load after emission or on a full matrix starts a new one
            wr_en = 1'b1;
            if (!starting || (loaded_reg >= total_cfg))
            begin
                wr_addr      = '0;
                loaded_next  = CNT_W'(1);
                emitted_next = '0;
            end
            else
            begin
                loaded_next = loaded_reg + CNT_W'(1);
            end
        end
        else if (in_accept && !emit_none)
        begin
            // emit: read, count, then step unless this was the last word
            rd_en             = 1'b1;
            emitted_next      = emitted_inc;
            spiral_total_next = total_use;
            spiral_cols_next  = eff_cols;
            top_next          = eff_top;
            left_next         = eff_left;
            bottom_next       = eff_bottom;
            right_next        = eff_right;
            row_next          = eff_row;
            col_next          = eff_col;
            dir_next          = eff_dir;
            if (!emit_last)
            begin
                top_next    = adv_top;
                left_next   = adv_left;
                bottom_next = adv_bottom;
                right_next  = adv_right;
                row_next    = adv_row;
                col_next    = adv_col;
                dir_next    = adv_dir;
            end
        end
    end

    // Read stage and output register control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_none_next  = s1_none_reg;
        s1_last_next  = s1_last_reg;
        if (in_accept)
        begin
            s1_valid_next = (cmd == somr_pkg::CMD_EMIT);
            s1_none_next  = emit_none;
            s1_last_next  = emit_last && !emit_none;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg         <= somr_pkg::CFG_WIDTH'(1);
            cols_reg         <= somr_pkg::CFG_WIDTH'(1);
            loaded_reg       <= '0;
            emitted_reg      <= '0;
            spiral_total_reg <= CNT_W'(1);
            spiral_cols_reg  <= DIM_W'(1);
            top_reg          <= '0;
            left_reg         <= '0;
            bottom_reg       <= '0;
            right_reg        <= '0;
            row_reg          <= '0;
            col_reg          <= '0;
            dir_reg          <= somr_pkg::DIR_RIGHT;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == somr_pkg::REG_ROW_COUNT))
            begin
                rows_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == somr_pkg::REG_COLUMN_COUNT))
            begin
                cols_reg <= cfg_data;
            end
            loaded_reg       <= loaded_next;
            emitted_reg      <= emitted_next;
            spiral_total_reg <= spiral_total_next;
            spiral_cols_reg  <= spiral_cols_next;
            top_reg          <= top_next;
            left_reg         <= left_next;
            bottom_reg       <= bottom_next;
            right_reg        <= right_next;
            row_reg          <= row_next;
            col_reg          <= col_next;
            dir_reg          <= dir_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_none_reg <= s1_none_next;
        s1_last_reg <= s1_last_next;
        if (out_load)
        begin
            out_none_reg <= s1_none_reg;
            out_last_reg <= s1_last_reg;
            out_elem_reg <= s1_none_reg ? '0 : rd_data;
        end
    end

    // Matrix store
    somr_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (element_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Outputs
    assign out_valid      = out_valid_reg;
    assign element_out    = out_elem_reg;
    assign last_of_spiral = out_last_reg;
    assign none_left      = out_none_reg;

    // Assertions
    `SOMR_ASSERT_IMP(a_none_zero, clk, rst_n, out_valid_reg && out_none_reg,
        (out_elem_reg == '0) && !out_last_reg, "none_left word carries data")
    `SOMR_ASSERT_IMP(a_count_bound, clk, rst_n, emitted_reg != '0,
        emitted_reg <= spiral_total_reg, "emit count passed spiral size")
    `SOMR_ASSERT_NXT(a_emit_stage, clk, rst_n, in_accept && (cmd == somr_pkg::CMD_EMIT),
        s1_valid_reg, "accepted emit word missing from read stage")
    `SOMR_ASSERT_IMP(a_full_stall, clk, rst_n, s1_valid_reg && out_valid_reg && out_stall,
        in_stall, "input accepted with pipeline full")
    `SOMR_ASSERT_NXT(a_last_done, clk, rst_n, rd_en && emit_last,
        emitted_reg == spiral_total_reg, "last word without finished count")

endmodule

>>> dv/spiral_order_matrix_reader_unit_tb.sv
// ----------------------------------------------------------------------------
// Spiral order matrix reader - testbench
// Loads matrices of many sizes word by word, requests their elements in
// spiral order and checks each result word against a local prediction of the
// walk, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module spiral_order_matrix_reader_unit_tb;

    localparam int EW            = somr_pkg::ELEM_WIDTH_DEF;
    localparam int MD            = somr_pkg::MAX_DIM_DEF;
    localparam int CELLS         = MD * MD;
    localparam int RANDOM_WORDS  = 800;
    localparam int IDLE_PCT      = 19;
    localparam int HANG_LIMIT    = 500;
    localparam int SETTLE_CYCLES = 4;

    // One result word as the block should return it
    typedef struct packed {
        logic [EW-1:0] value;
        logic          last;
        logic          none;
    } spiral_result_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic                                cmd = somr_pkg::CMD_LOAD;
    logic signed [EW-1:0]                element_in = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [EW-1:0]                element_out;
    logic                                last_of_spiral;
    logic                                none_left;
    logic                                cfg_write = 1'b0;
    logic [somr_pkg::CFG_INDEX_W-1:0]    cfg_index = somr_pkg::REG_ROW_COUNT;
    logic [somr_pkg::CFG_WIDTH-1:0]      cfg_data = '0;

    // Gaps and stalls are off while this is set
    bit steady_flow = 1'b0;

    int unsigned errors = 0;
    int unsigned n_loads = 0;
    int unsigned n_emits = 0;
    int unsigned n_checked = 0;
    int unsigned n_none = 0;
    int unsigned n_dim_settings = 0;
    int unsigned quiet_cycles = 0;

    // Predicted block state
    logic [somr_pkg::CFG_WIDTH-1:0] row_reg = 7'd1;
    logic [somr_pkg::CFG_WIDTH-1:0] col_reg = 7'd1;
    logic [EW-1:0]        matrix_copy [CELLS];
    int unsigned          loaded = 0;
    int unsigned          emitted = 0;
    int unsigned          spiral_rows = 1;
    int unsigned          spiral_cols = 1;
    int                   ring_top, ring_bottom, ring_left, ring_right;
    int                   walk_row, walk_col;
    somr_pkg::dir_t       walk_dir = somr_pkg::DIR_RIGHT;

    spiral_result_t       awaited_results [$];

    always #1 clk = ~clk;

    spiral_order_matrix_reader_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .element_in     (element_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .element_out    (element_out),
        .last_of_spiral (last_of_spiral),
        .none_left      (none_left),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Register value 0 means 1, anything above the maximum means the maximum
    function automatic int unsigned used_dim(input logic [somr_pkg::CFG_WIDTH-1:0] v);
        if (v == 0)
            return 1;
        if (v > MD)
            return MD;
        return 32'(v);
    endfunction

    function automatic int unsigned matrix_cells();
        return used_dim(row_reg) * used_dim(col_reg);
    endfunction

    // Latch the dimensions and put the walk at the top left corner
    function automatic void begin_spiral();
        spiral_rows = used_dim(row_reg);
        spiral_cols = used_dim(col_reg);
        ring_top    = 0;
        ring_left   = 0;
        ring_bottom = int'(spiral_rows) - 1;
        ring_right  = int'(spiral_cols) - 1;
        walk_dir    = somr_pkg::DIR_RIGHT;
        walk_row    = 0;
        walk_col    = 0;
    endfunction

    // One clockwise step; a turn shrinks the ring side just finished
    function automatic void step_walk();
        case (walk_dir)
            somr_pkg::DIR_RIGHT:
                if (walk_col < ring_right)
                    walk_col++;
                else
                begin
                    ring_top++;
                    walk_dir = somr_pkg::DIR_DOWN;
                    walk_row++;
                end
            somr_pkg::DIR_DOWN:
                if (walk_row < ring_bottom)
                    walk_row++;
                else
                begin
                    ring_right--;
                    walk_dir = somr_pkg::DIR_LEFT;
                    walk_col--;
                end
            somr_pkg::DIR_LEFT:
                if (walk_col > ring_left)
                    walk_col--;
                else
                begin
                    ring_bottom--;
                    walk_dir = somr_pkg::DIR_UP;
                    walk_row--;
                end
            default:
                if (walk_row > ring_top)
                    walk_row--;
                else
                begin
                    ring_left++;
                    walk_dir = somr_pkg::DIR_RIGHT;
                    walk_col++;
                end
        endcase
    endfunction

    // Update the predicted state for one accepted word; emits queue a result
    function automatic void apply_word(input logic kind, input logic [EW-1:0] value);
        spiral_result_t res;
        int unsigned    total;
        res = '0;
        if (kind == somr_pkg::CMD_LOAD)
        begin
            // full matrix or spiral under way: this word starts a new matrix
            if (emitted != 0 || loaded >= matrix_cells())
            begin
                loaded  = 0;
                emitted = 0;
            end
            matrix_copy[loaded % CELLS] = value;
            loaded++;
            return;
        end
        if (emitted == 0)
        begin
            if (loaded < matrix_cells())
            begin
                res.none = 1'b1;
                awaited_results.push_back(res);
                return;
            end
            begin_spiral();
        end
        total = spiral_rows * spiral_cols;
        if (emitted >= total)
        begin
            res.none = 1'b1;
            awaited_results.push_back(res);
            return;
        end
        res.value = matrix_copy[(walk_row * spiral_cols + walk_col) % CELLS];
        emitted++;
        res.last = (emitted == total);
        awaited_results.push_back(res);
        if (emitted < total)
            step_walk();
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    always @(posedge clk)
    begin : check_results
        spiral_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
                flag_mismatch($sformatf("result word %0d with nothing expected",
                                        $signed(element_out)));
            else
            begin
                want = awaited_results.pop_front();
                n_checked++;
                if (want.none)
                    n_none++;
                if (element_out !== want.value)
                    flag_mismatch($sformatf("result %0d: element_out %0d, expected %0d",
                                            n_checked, $signed(element_out),
                                            $signed(want.value)));
                if (last_of_spiral !== want.last)
                    flag_mismatch($sformatf("result %0d: last_of_spiral %b, expected %b",
                                            n_checked, last_of_spiral, want.last));
                if (none_left !== want.none)
                    flag_mismatch($sformatf("result %0d: none_left %b, expected %b",
                                            n_checked, none_left, want.none));
            end
        end
    end

    // Receiver stalls
    always @(posedge clk)
        out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);

    // Watchdog: end the run when no word moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == HANG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", HANG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [EW-1:0] rand_elem();
        logic [EW-1:0] pick;
        case ($urandom_range(19))
            0:       pick = {1'b1, {(EW-1){1'b0}}};
            1:       pick = {1'b0, {(EW-1){1'b1}}};
            2:       pick = '0;
            3:       pick = '1;
            default: pick = EW'($urandom);
        endcase
        return pick;
    endfunction

    // Mostly small sizes, a few wide ones and out-of-range register values
    function automatic logic [somr_pkg::CFG_WIDTH-1:0] random_dim();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 75)
            return 7'($urandom_range(6, 1));
        if (p < 88)
            return 7'($urandom_range(16, 7));
        if (p < 94)
            return $urandom_range(1) ? 7'd0 : 7'($urandom_range(127, 65));
        return 7'($urandom_range(64, 17));
    endfunction

    // Send one word, with random gaps ahead of it, and wait for acceptance
    task automatic send_word(input logic kind, input logic [EW-1:0] value);
        if (!steady_flow)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid   <= 1'b1;
        cmd        <= kind;
        element_in <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_word(kind, value);
        if (kind == somr_pkg::CMD_LOAD)
            n_loads++;
        else
            n_emits++;
    endtask

    task automatic run_matrix(input int unsigned loads, input int unsigned emits);
        repeat (loads)
            send_word(somr_pkg::CMD_LOAD, rand_elem());
        repeat (emits)
            send_word(somr_pkg::CMD_EMIT, EW'($urandom));
    endtask

    // Stop sending and wait until the block has gone quiet
    task automatic drain_words();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [somr_pkg::CFG_INDEX_W-1:0] index,
                             input logic [somr_pkg::CFG_WIDTH-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        if (index == somr_pkg::REG_ROW_COUNT)
            row_reg = data;
        else
            col_reg = data;
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_dims(input logic [somr_pkg::CFG_WIDTH-1:0] rows,
                            input logic [somr_pkg::CFG_WIDTH-1:0] cols);
        drain_words();
        write_reg(somr_pkg::REG_ROW_COUNT, rows);
        write_reg(somr_pkg::REG_COLUMN_COUNT, cols);
        n_dim_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // 1x1 after reset: emit before load, single element, emit after done, reload
    task automatic test_reset_state();
        send_word(somr_pkg::CMD_EMIT, EW'($urandom));
        send_word(somr_pkg::CMD_LOAD, {1'b1, {(EW-1){1'b0}}});
        send_word(somr_pkg::CMD_EMIT, EW'($urandom));
        send_word(somr_pkg::CMD_EMIT, EW'($urandom));
        send_word(somr_pkg::CMD_LOAD, {1'b0, {(EW-1){1'b1}}});
        send_word(somr_pkg::CMD_EMIT, EW'($urandom));
    endtask

    // Zero registers count as one; 3x3 with an early emit and a center element
    task automatic test_clamp_and_ring();
        set_dims(7'd0, 7'd0);
        run_matrix(1, 1);
        set_dims(7'd3, 7'd3);
        run_matrix(4, 1);
        run_matrix(5, 10);
    endtask

    // Single row and column at full width, then a full-height clamped matrix
    task automatic test_edge_sizes();
        set_dims(7'd1, 7'(MD));
        run_matrix(MD, MD + 1);
        set_dims(7'(MD), 7'd1);
        run_matrix(MD, MD + 1);
        // a row register above the maximum clamps; run this one without gaps
        set_dims(7'h7F, 7'd2);
        steady_flow = 1'b1;
        run_matrix(MD * 2, MD * 2 + 1);
        drain_words();
        steady_flow = 1'b0;
    endtask

    // Random phases: mostly whole matrices, plus partial spirals, reloads,
    // size changes mid-spiral and random noise
    task automatic test_random_traffic();
        int unsigned start;
        int unsigned total;
        int unsigned part;
        logic [somr_pkg::CFG_WIDTH-1:0] r, c;
        start = n_loads + n_emits;
        while (n_loads + n_emits - start < RANDOM_WORDS)
        begin
            if ($urandom_range(9) < 7)
            begin
                r = random_dim();
                c = random_dim();
                if (used_dim(r) * used_dim(c) > 256)
                    c = 7'($urandom_range(4, 1));
                set_dims(r, c);
            end
            total = matrix_cells();
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5:
                    run_matrix(total, total + ($urandom_range(3) == 0));
                6:
                begin
                    // reload while the spiral is under way
                    part = $urandom_range(total, 1);
                    run_matrix(total, part);
                    run_matrix(total, total);
                end
                7:
                    // keep emitting, possibly with the sizes just changed
                    run_matrix(0, $urandom_range(total + 1, 1));
                8:
                    repeat ($urandom_range(20, 1))
                        send_word(1'($urandom_range(1)), rand_elem());
                default:
                begin
                    // emit before the matrix is complete, then finish it
                    part = $urandom_range(total - 1, 0);
                    run_matrix(part, $urandom_range(2, 1));
                    run_matrix(total - part, total);
                end
            endcase
            drain_words();
        end
    endtask

    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_clamp_and_ring();
        test_edge_sizes();
        test_random_traffic();
        drain_words();
        repeat (8)
            @(posedge clk);
        if (awaited_results.size() != 0)
            flag_mismatch($sformatf("%0d result words never arrived",
                                    awaited_results.size()));
        $display("Sent %0d load words and %0d emit words over %0d size settings, up to %0d per side.",
                 n_loads, n_emits, n_dim_settings, MD);
        $display("Checked %0d result words, %0d of them none-left; %0d mismatches.",
                 n_checked, n_none, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
